>>> rtl/lrts_pkg.sv
// Package for the longest-remaining-time scheduler core.
// Holds sizes and the command and result types used by the rtl files, and the engine's candidate compare.
// Depends on nothing.
package lrts_pkg;

  localparam int JOB_SLOTS  = 16;
  localparam int TIME_BITS  = 16;
  localparam int SLOT_BITS  = $clog2(JOB_SLOTS);
  localparam int CAND_N     = 1 << SLOT_BITS;
  localparam int RCNT_BITS  = $clog2(SLOT_BITS + 1);
  localparam int FIELD_BITS = 16;
  localparam int SLOTF_BITS = 4;

  // Opcodes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Command kinds after classification by the front end.
  localparam logic [1:0] CMD_NOP  = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_BITS-1:0]  slot;
    logic [FIELD_BITS-1:0] arrival;
    logic [FIELD_BITS-1:0] burst;
  } cmd_t;

  typedef struct packed {
    logic                  ran_valid;
    logic [SLOTF_BITS-1:0] ran_slot;
    logic [FIELD_BITS-1:0] tick_start;
    logic                  job_finished;
    logic [FIELD_BITS-1:0] completion_time;
    logic [FIELD_BITS-1:0] turnaround_time;
    logic [FIELD_BITS-1:0] waiting_time;
  } res_t;

  typedef struct packed {
    logic                  valid;
    logic [SLOT_BITS-1:0]  slot;
    logic [FIELD_BITS-1:0] rem;
  } cand_t;

  // Keeps the lower-slot candidate unless the upper one has strictly more work left.
  function automatic cand_t cand_better(cand_t lo, cand_t hi);
    cand_t r;
    r = lo;
    if (hi.valid && (!lo.valid || hi.rem > lo.rem)) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

>>> rtl/lrts_front.sv
// Front end of the scheduler: accepts input items, classifies them and queues commands.
// Depends on lrts_pkg.
module lrts_front
  import lrts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode,
  input  logic [SLOTF_BITS-1:0] job_slot,
  input  logic [FIELD_BITS-1:0] arrival_time,
  input  logic [FIELD_BITS-1:0] burst_time,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       pop_ok;
  cmd_t       cmd_in;

  // A load aimed past the last slot is turned into a no-op here.
  always_comb begin
    cmd_in.slot    = SLOT_BITS'(job_slot);
    cmd_in.arrival = arrival_time;
    cmd_in.burst   = burst_time;
    if (opcode == OP_TICK) begin
      cmd_in.kind = CMD_TICK;
    end else if (32'(job_slot) < JOB_SLOTS) begin
      cmd_in.kind = CMD_LOAD;
    end else begin
      cmd_in.kind = CMD_NOP;
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 2'd1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

>>> rtl/lrts_engine.sv
// Back end of the scheduler: slot state, admission, max search and per-tick update.
// Depends on lrts_pkg.
module lrts_engine
  import lrts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ADMIT  = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;
  localparam logic [1:0] S_APPLY  = 2'd3;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [1:0]            state;
  logic [RCNT_BITS-1:0]  rcnt;
  logic [TIME_BITS-1:0]  current_time;
  logic [JOB_SLOTS-1:0]  slot_loaded;
  logic [JOB_SLOTS-1:0]  slot_admitted;
  logic [FIELD_BITS-1:0] slot_arrival   [JOB_SLOTS];
  logic [FIELD_BITS-1:0] slot_remaining [CAND_N];
  logic [FIELD_BITS-1:0] slot_waiting   [JOB_SLOTS];
  cand_t                 cand [CAND_N];

  logic [JOB_SLOTS-1:0]  adm_next;
  logic [CAND_N-1:0]     cand_live;
  logic [TIME_BITS-1:0]  time_inc;
  logic                  apply_go;
  logic                  fin;
  cand_t                 win;

  always_comb begin
    for (int i = 0; i < JOB_SLOTS; i++) begin
      adm_next[i] = slot_admitted[i] |
                    (slot_loaded[i] && (32'(slot_arrival[i]) <= 32'(current_time)));
    end
  end

  assign cand_live = CAND_N'(slot_loaded & adm_next);
  assign win      = cand[0];
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign apply_go = (state == S_APPLY) && !res_full;
  assign res_push = apply_go;
  assign fin      = win.valid && (win.rem == FIELD_BITS'(1));
  assign time_inc = (current_time != TIME_MAX) ? current_time + TIME_BITS'(1) : current_time;

  always_comb begin
    res = '0;
    res.tick_start = FIELD_BITS'(current_time);
    if (win.valid) begin
      res.ran_valid = 1'b1;
      res.ran_slot  = SLOTF_BITS'(win.slot);
    end
    if (fin) begin
      res.job_finished    = 1'b1;
      res.completion_time = FIELD_BITS'(time_inc);
      res.turnaround_time = FIELD_BITS'(time_inc) - slot_arrival[win.slot];
      res.waiting_time    = slot_waiting[win.slot];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rcnt          <= '0;
      current_time  <= '0;
      slot_loaded   <= '0;
      slot_admitted <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.kind == CMD_TICK) begin
              state <= S_ADMIT;
            end else if (cmd.kind == CMD_LOAD) begin
              slot_loaded[cmd.slot]   <= (cmd.burst != '0);
              slot_admitted[cmd.slot] <= 1'b0;
            end
          end
        end
        S_ADMIT: begin
          slot_admitted <= adm_next;
          rcnt          <= '0;
          state         <= S_REDUCE;
        end
        S_REDUCE: begin
          rcnt <= rcnt + RCNT_BITS'(1);
          if (rcnt == RCNT_BITS'(SLOT_BITS - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!res_full) begin
            current_time <= time_inc;
            if (fin) begin
              slot_loaded[win.slot]   <= 1'b0;
              slot_admitted[win.slot] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Slot payload and candidate tree.
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_LOAD) begin
      slot_arrival[cmd.slot]   <= cmd.arrival;
      slot_remaining[cmd.slot] <= cmd.burst;
      slot_waiting[cmd.slot]   <= '0;
    end
    if (state == S_ADMIT) begin
      for (int i = 0; i < CAND_N; i++) begin
        cand[i].valid <= cand_live[i];
        cand[i].slot  <= SLOT_BITS'(i);
        cand[i].rem   <= slot_remaining[i];
      end
    end
    // Each pass halves the live candidates; the winner lands in entry zero.
    if (state == S_REDUCE) begin
      for (int i = 0; i < CAND_N / 2; i++) begin
        cand[i] <= cand_better(cand[2 * i], cand[2 * i + 1]);
      end
    end
    if (apply_go && win.valid) begin
      for (int i = 0; i < JOB_SLOTS; i++) begin
        if (slot_loaded[i] && slot_admitted[i] && (SLOT_BITS'(i) != win.slot) &&
            (slot_waiting[i] != '1)) begin
          slot_waiting[i] <= slot_waiting[i] + FIELD_BITS'(1);
        end
      end
      slot_remaining[win.slot] <= win.rem - FIELD_BITS'(1);
    end
  end

  a_idle_not_finished: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res.ran_valid || !res.job_finished))
    else $error("finished flag on an idle tick");

  a_admitted_loaded: assert property (@(posedge clk) disable iff (rst)
    (slot_admitted & ~slot_loaded) == '0)
    else $error("slot admitted without a loaded job");

  a_push_then_idle: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (state == S_IDLE))
    else $error("engine did not return to idle after a result");

  a_time_only_on_apply: assert property (@(posedge clk) disable iff (rst)
    (state != S_APPLY) |=> $stable(current_time))
    else $error("time moved outside a tick update");

endmodule

>>> rtl/lrts_res_fifo.sv
// Two-entry result queue between the scheduler engine and the result port.
// Depends on lrts_pkg.
module lrts_res_fifo
  import lrts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_in,
  output logic res_full,
  input  logic pop,
  output logic empty,
  output res_t res_out
);

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       pop_ok;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign push_ok  = res_push && !res_full;
  assign pop_ok   = pop && !empty;
  assign res_out  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 2'd1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= res_in;
    end
  end

endmodule

>>> rtl/longest_remaining_time_scheduler_core.sv
// Top level of the longest-remaining-time-first scheduler core.
// Depends on lrts_pkg, lrts_front, lrts_engine and lrts_res_fifo.
//
// Usage: items enter through a queue-style port. A transfer happens on a rising edge
// with push high and full low. Opcode load writes a job (arrival, burst) into a slot;
// opcode tick runs one scheduler time unit. Loads give no result; every tick gives
// exactly one result. Results leave through a second queue-style port: the oldest
// result sits on the result ports while empty is low and is transferred on an edge
// with pop high.
// Flow: a two-entry command queue sits in front of the engine and a two-entry
// result queue behind it. A load is carried out as the engine takes it. A tick
// takes the command, admits arrived jobs, runs one pass per level of the max-search
// tree, each pass halving the candidate set, and then updates the slots and writes
// the result, waiting there while the result queue is full. The tree passes set
// the tick rate.
// Reset (rst, synchronous) empties both queues, sets time to zero and frees all slots.
// When the receiver stops popping, the result queue fills, the engine holds its
// finished tick, the command queue fills and full rises; nothing is lost.
module longest_remaining_time_scheduler_core
  import lrts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode,
  input  logic [SLOTF_BITS-1:0] job_slot,
  input  logic [FIELD_BITS-1:0] arrival_time,
  input  logic [FIELD_BITS-1:0] burst_time,
  output logic                  empty,
  input  logic                  pop,
  output logic                  ran_valid,
  output logic [SLOTF_BITS-1:0] ran_slot,
  output logic [FIELD_BITS-1:0] tick_start,
  output logic                  job_finished,
  output logic [FIELD_BITS-1:0] completion_time,
  output logic [FIELD_BITS-1:0] turnaround_time,
  output logic [FIELD_BITS-1:0] waiting_time
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res;
  res_t res_out;

  // The front end classifies each item and queues it for the engine.
  lrts_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .job_slot     (job_slot),
    .arrival_time (arrival_time),
    .burst_time   (burst_time),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // The engine holds all slot state and carries out loads and ticks.
  lrts_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Finished tick results wait here until the receiver pops them.
  lrts_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_out)
  );

  assign ran_valid       = res_out.ran_valid;
  assign ran_slot        = res_out.ran_slot;
  assign tick_start      = res_out.tick_start;
  assign job_finished    = res_out.job_finished;
  assign completion_time = res_out.completion_time;
  assign turnaround_time = res_out.turnaround_time;
  assign waiting_time    = res_out.waiting_time;

endmodule

>>> tb/sv/longest_remaining_time_scheduler_core_tb.sv
// Self-checking testbench for longest_remaining_time_scheduler_core.
// Predicts every tick result in SystemVerilog and checks each popped result in order.
// Depends on lrts_pkg and the scheduler core rtl.
module longest_remaining_time_scheduler_core_tb;
  import lrts_pkg::*;

  // A receiver hold-off long enough to fill both internal queues many times over.
  localparam int HOLD_CYCLES   = 150;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT   = 1000;
  // A tick passes through the engine and both queues; this covers any straggler.
  localparam int SETTLE_CYCLES = 20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic                  opcode = OP_LOAD;
  logic [SLOTF_BITS-1:0] job_slot = '0;
  logic [FIELD_BITS-1:0] arrival_time = '0;
  logic [FIELD_BITS-1:0] burst_time = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  ran_valid;
  logic [SLOTF_BITS-1:0] ran_slot;
  logic [FIELD_BITS-1:0] tick_start;
  logic                  job_finished;
  logic [FIELD_BITS-1:0] completion_time;
  logic [FIELD_BITS-1:0] turnaround_time;
  logic [FIELD_BITS-1:0] waiting_time;

  // Knobs shared between the stimulus and the result taker.
  bit send_idle = 1'b0;
  bit take_idle = 1'b0;
  bit hold_request = 1'b0;

  int mismatch_count = 0;
  int idle_cycles = 0;

  // Our own copy of the scheduler state, advanced at every accepted input transfer.
  logic [FIELD_BITS-1:0] sched_now = '0;
  logic                  job_loaded  [JOB_SLOTS] = '{default: 1'b0};
  logic                  job_ready   [JOB_SLOTS] = '{default: 1'b0};
  logic [FIELD_BITS-1:0] job_arrival [JOB_SLOTS] = '{default: '0};
  logic [FIELD_BITS-1:0] job_left    [JOB_SLOTS] = '{default: '0};
  logic [FIELD_BITS-1:0] job_wait    [JOB_SLOTS] = '{default: '0};

  // Tick results still owed by the block, oldest first.
  res_t runs_due[$];

  longest_remaining_time_scheduler_core u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .opcode          (opcode),
    .job_slot        (job_slot),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .empty           (empty),
    .pop             (pop),
    .ran_valid       (ran_valid),
    .ran_slot        (ran_slot),
    .tick_start      (tick_start),
    .job_finished    (job_finished),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted item to the scheduler copy. A load only rewrites its slot.
  // A tick admits arrived jobs, runs the one with the most work left (lowest slot on
  // a tie), ages the others and queues the result the block must produce.
  function automatic void apply_item(input logic op, input logic [SLOTF_BITS-1:0] slot,
                                     input logic [FIELD_BITS-1:0] arr,
                                     input logic [FIELD_BITS-1:0] len);
    res_t run;
    int i;
    int pick;
    logic [FIELD_BITS-1:0] most;
    if (op == OP_LOAD) begin
      // A zero burst leaves the slot free; any reload starts the job over.
      job_loaded[slot]  = (len != '0);
      job_ready[slot]   = 1'b0;
      job_arrival[slot] = arr;
      job_left[slot]    = len;
      job_wait[slot]    = '0;
      return;
    end
    run = '0;
    run.tick_start = sched_now;
    for (i = 0; i < JOB_SLOTS; i++) begin
      if (job_loaded[i] && !job_ready[i] && job_arrival[i] <= sched_now) begin
        job_ready[i] = 1'b1;
      end
    end
    pick = -1;
    most = '0;
    for (i = 0; i < JOB_SLOTS; i++) begin
      if (job_loaded[i] && job_ready[i] && (pick < 0 || job_left[i] > most)) begin
        pick = i;
        most = job_left[i];
      end
    end
    // Time stops at its maximum value but ticks keep running.
    if (sched_now != '1) begin
      sched_now++;
    end
    if (pick >= 0) begin
      for (i = 0; i < JOB_SLOTS; i++) begin
        if (i != pick && job_loaded[i] && job_ready[i] && job_wait[i] != '1) begin
          job_wait[i]++;
        end
      end
      run.ran_valid = 1'b1;
      run.ran_slot = pick[SLOTF_BITS-1:0];
      job_left[pick]--;
      if (job_left[pick] == '0) begin
        run.job_finished    = 1'b1;
        run.completion_time = sched_now;
        run.turnaround_time = sched_now - job_arrival[pick];
        run.waiting_time    = job_wait[pick];
        job_loaded[pick]    = 1'b0;
        job_ready[pick]     = 1'b0;
      end
    end
    runs_due.insert(runs_due.size(), run);
  endfunction

  // Offers one item after an optional random gap and returns at the edge of its
  // transfer. Push is left high so back-to-back items need no extra edge.
  task automatic offer_item(input logic op, input logic [SLOTF_BITS-1:0] slot,
                            input logic [FIELD_BITS-1:0] arr,
                            input logic [FIELD_BITS-1:0] len);
    int gap;
    gap = send_idle ? $urandom_range(10) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    opcode       <= op;
    job_slot     <= slot;
    arrival_time <= arr;
    burst_time   <= len;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_item(op, slot, arr, len);
  endtask

  // The sender stops and waits until every owed result has been popped.
  task automatic wait_all_results();
    push <= 1'b0;
    @(posedge clk);
    while (runs_due.size() != 0) @(posedge clk);
  endtask

  // Mixed loads and ticks. Most jobs are short and arrive near the current time so
  // that they are admitted, compete and finish; a few are huge or arrive far off,
  // and some loads free a slot with a zero burst.
  task automatic run_random_traffic(input int count);
    int n;
    int pick;
    int near;
    logic op;
    logic [SLOTF_BITS-1:0] slot;
    logic [FIELD_BITS-1:0] arr;
    logic [FIELD_BITS-1:0] len;
    for (n = 0; n < count; n++) begin
      op = ($urandom_range(99) < 55) ? OP_TICK : OP_LOAD;
      slot = SLOTF_BITS'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 6) begin
        len = '0;
      end else if (pick < 9) begin
        len = FIELD_BITS'($urandom_range(65535));
      end else begin
        len = FIELD_BITS'($urandom_range(6, 1));
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        arr = FIELD_BITS'($urandom_range(65535));
      end else if (pick < 30) begin
        arr = (sched_now > 8) ? sched_now - FIELD_BITS'($urandom_range(8)) : '0;
      end else begin
        near = int'(sched_now) + $urandom_range(8);
        arr = (near > 65535) ? '1 : FIELD_BITS'(near);
      end
      offer_item(op, slot, arr, len);
    end
  endtask

  // Idle tick on an empty scheduler, a tie between the lowest and highest slot, a
  // job admitted exactly at its arrival time, an all-ones job that never arrives,
  // a reload of a running slot and freeing slots with a zero burst.
  task automatic run_directed_cases();
    send_idle = 1'b0;
    take_idle = 1'b1;
    offer_item(OP_TICK, '0, '0, '0);
    offer_item(OP_LOAD, 4'd0, 16'd0, 16'd3);
    offer_item(OP_LOAD, 4'd15, 16'd0, 16'd3);
    offer_item(OP_LOAD, 4'd7, 16'd4, 16'd1);
    offer_item(OP_LOAD, 4'd9, '1, '1);
    repeat (4) offer_item(OP_TICK, '0, '0, '0);
    offer_item(OP_LOAD, 4'd15, 16'd0, 16'd4);
    offer_item(OP_LOAD, 4'd0, 16'd0, 16'd0);
    offer_item(OP_LOAD, 4'd9, 16'd0, 16'd0);
    repeat (10) offer_item(OP_TICK, '0, '0, '0);
    wait_all_results();
  endtask

  // Both sides idle at random, so gaps land on every cycle of a tick.
  task automatic run_idle_mix();
    send_idle = 1'b1;
    take_idle = 1'b1;
    run_random_traffic(1490);
  endtask

  // Full rate on both sides.
  task automatic run_steady_stream();
    send_idle = 1'b0;
    take_idle = 1'b0;
    run_random_traffic(300);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering, so the
  // result queue, the engine and the command queue all fill and full rises.
  task automatic run_backpressure();
    send_idle = 1'b0;
    take_idle = 1'b0;
    hold_request = 1'b1;
    run_random_traffic(40);
    wait_all_results();
  endtask

  // Result side: a random wait before each result, or one long hold when asked.
  // Pop is only lowered when a wait follows, so it never toggles within one step.
  initial begin : result_taker
    int gap;
    wait (!rst);
    forever begin
      gap = take_idle ? $urandom_range(10) : 0;
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Every popped result is matched against the oldest owed one, field by field.
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && pop && !empty) begin
      if (runs_due.size() == 0) begin
        $error("unexpected result: ran_slot %0d tick_start %0d", ran_slot, tick_start);
        mismatch_count++;
      end else begin
        want = runs_due.pop_front();
        if (ran_valid !== want.ran_valid) begin
          $error("ran_valid: expected %0d, got %0d", want.ran_valid, ran_valid);
          mismatch_count++;
        end
        if (ran_slot !== want.ran_slot) begin
          $error("ran_slot: expected %0d, got %0d", want.ran_slot, ran_slot);
          mismatch_count++;
        end
        if (tick_start !== want.tick_start) begin
          $error("tick_start: expected %0d, got %0d", want.tick_start, tick_start);
          mismatch_count++;
        end
        if (job_finished !== want.job_finished) begin
          $error("job_finished: expected %0d, got %0d", want.job_finished, job_finished);
          mismatch_count++;
        end
        if (completion_time !== want.completion_time) begin
          $error("completion_time: expected %0d, got %0d",
                 want.completion_time, completion_time);
          mismatch_count++;
        end
        if (turnaround_time !== want.turnaround_time) begin
          $error("turnaround_time: expected %0d, got %0d",
                 want.turnaround_time, turnaround_time);
          mismatch_count++;
        end
        if (waiting_time !== want.waiting_time) begin
          $error("waiting_time: expected %0d, got %0d", want.waiting_time, waiting_time);
          mismatch_count++;
        end
      end
    end
  end

  // Hang detection: any transfer on either side restarts the count.
  always @(posedge clk) begin : stall_watch
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : test_sequence
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed_cases();
    run_idle_mix();
    run_steady_stream();
    run_backpressure();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
